@@ rtl/ptp_pkg.sv @@
// Shared types and constants of the partition table probe.
package ptp_pkg;

  localparam int SECTOR_BYTES_DEF = 512;
  localparam int MAGIC_OFFSET_DEF = 510;
  localparam int ENTRY_COUNT_DEF  = 16;
  localparam int ENTRY_BYTES_DEF  = 32;

  localparam int BYTE_W       = 8;
  localparam int VERDICT_W    = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 48;
  localparam int SECT_SIZE_W  = 16;
  localparam int MEDIA_SIZE_W = 48;
  localparam int MAGIC_W      = 16;

  localparam logic [SECT_SIZE_W-1:0]  SECTOR_SIZE_RST = 16'd512;
  localparam logic [MEDIA_SIZE_W-1:0] MEDIA_SIZE_RST  = 48'd8192;
  localparam logic [MAGIC_W-1:0]      MAGIC_VALUE_RST = 16'hAA55;
  localparam logic [MEDIA_SIZE_W-1:0] MIN_MEDIA       = 48'd8192;

  // Byte offsets within one table entry
  localparam int OFF_TYPE0     = 0;
  localparam int OFF_TYPE1     = 1;
  localparam int OFF_START_SEC = 8;
  localparam int OFF_START_HD  = 9;
  localparam int OFF_START_CYL = 10;
  localparam int OFF_START_CYH = 11;
  localparam int OFF_END_SEC   = 12;
  localparam int OFF_END_HD    = 13;
  localparam int OFF_END_CYL   = 14;
  localparam int OFF_END_CYH   = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SECTOR_SIZE = 2'd0,
    REG_MEDIA_SIZE  = 2'd1,
    REG_MAGIC_VALUE = 2'd2
  } cfg_reg_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_NO_TABLE   = 3'd0,
    VERDICT_EMPTY      = 3'd1,
    VERDICT_VALID      = 3'd2,
    VERDICT_TOO_SMALL  = 3'd3,
    VERDICT_BAD_SECTOR = 3'd4
  } verdict_t;

  // Control passed to the entry checker with each accepted word
  typedef struct packed {
    logic tbl_byte;   // word belongs to the second sector
    logic frame_end;  // last word of the frame
  } ptp_step_t;

endpackage

@@ rtl/ptp_ifs.sv @@
// Handshake channel interfaces of the partition table probe.
interface ptp_byte_if
  import ptp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ptp_verdict_if
  import ptp_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

interface ptp_cfg_if
  import ptp_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/partition_table_probe.sv @@
// Top level of the partition table probe: byte stream in, one verdict per frame out.
// The probe takes the first two sectors of a disk as a stream of bytes, one byte per
// cycle while not stalled, and gives one verdict word after the last byte of each
// frame of 2*SECTOR_BYTES bytes; other bytes give no result. The state is updated
// as each byte is accepted and the verdict lands in an output register, so
// in_byte.ready stays high unless a verdict sits unread in that register.
// Configuration is sampled at the last byte of a frame; writes are taken at any
// time (cfg_wr.ready is always high) and an index past the register list is
// ignored. Verdicts: 0 no valid table, 1 empty table, 2 valid table, 3 medium or
// sector size too small, 4 sector size unsupported (too large).
module partition_table_probe
  import ptp_pkg::*;
#(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int MAGIC_OFFSET = MAGIC_OFFSET_DEF,
  parameter int ENTRY_COUNT  = ENTRY_COUNT_DEF,
  parameter int ENTRY_BYTES  = ENTRY_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ptp_byte_if.sink      in_byte,
  ptp_verdict_if.source out_verdict,
  ptp_cfg_if.sink       cfg_wr
);

  localparam int POS_W = $clog2(2 * SECTOR_BYTES);

  logic [SECT_SIZE_W-1:0]  sector_size_r;
  logic [MEDIA_SIZE_W-1:0] media_size_r;
  logic [MAGIC_W-1:0]      magic_value_r;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] magic_lo_r, magic_lo_nxt;
  logic              magic_ok_r, magic_ok_nxt;
  logic              any_nz_r, any_nz_nxt;
  logic              out_valid_r, out_valid_nxt;
  verdict_t          verdict_r, verdict_nxt;

  logic              in_fire;
  logic              last;
  logic              tbl;
  logic              entry_failed;
  ptp_step_t         step;

  assign in_byte.ready       = !out_valid_r || out_verdict.ready;
  assign in_fire             = in_byte.valid && in_byte.ready;
  assign last                = (pos_r == POS_W'(2 * SECTOR_BYTES - 1));
  assign tbl                 = (pos_r >= POS_W'(SECTOR_BYTES));
  assign step.tbl_byte       = tbl;
  assign step.frame_end      = last;
  assign out_verdict.valid   = out_valid_r;
  assign out_verdict.verdict = verdict_r;
  assign cfg_wr.ready        = 1'b1;

  ptp_entry_check #(
    .ENTRY_COUNT(ENTRY_COUNT),
    .ENTRY_BYTES(ENTRY_BYTES)
  ) u_entry (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .step_valid(in_fire),
    .data_byte (in_byte.data_byte),
    .failed    (entry_failed)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_size_r <= SECTOR_SIZE_RST;
      media_size_r  <= MEDIA_SIZE_RST;
      magic_value_r <= MAGIC_VALUE_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_SECTOR_SIZE: sector_size_r <= cfg_wr.data[SECT_SIZE_W-1:0];
        REG_MEDIA_SIZE:  media_size_r  <= cfg_wr.data[MEDIA_SIZE_W-1:0];
        REG_MAGIC_VALUE: magic_value_r <= cfg_wr.data[MAGIC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    magic_lo_nxt = magic_lo_r;
    magic_ok_nxt = magic_ok_r;
    any_nz_nxt   = any_nz_r;
    if (in_fire && !tbl) begin
      if (pos_r == POS_W'(MAGIC_OFFSET)) magic_lo_nxt = in_byte.data_byte;
      else if (pos_r == POS_W'(MAGIC_OFFSET + 1))
        magic_ok_nxt = ({in_byte.data_byte, magic_lo_r} == magic_value_r);
    end
    if (in_fire && tbl && (in_byte.data_byte != '0)) any_nz_nxt = 1'b1;

    priority if ((sector_size_r < SECT_SIZE_W'(SECTOR_BYTES)) ||
                 (media_size_r < MIN_MEDIA))
      verdict_nxt = VERDICT_TOO_SMALL;
    else if (sector_size_r > SECT_SIZE_W'(SECTOR_BYTES))
      verdict_nxt = VERDICT_BAD_SECTOR;
    else if (!magic_ok_nxt)
      verdict_nxt = VERDICT_NO_TABLE;
    else if (!any_nz_nxt)
      verdict_nxt = VERDICT_EMPTY;
    else if (entry_failed)
      verdict_nxt = VERDICT_NO_TABLE;
    else
      verdict_nxt = VERDICT_VALID;

    pos_nxt = pos_r;
    if (in_fire) pos_nxt = last ? '0 : pos_r + 1'b1;

    // hold the verdict until taken
    out_valid_nxt = out_valid_r && !out_verdict.ready;
    if (in_fire && last) begin
      out_valid_nxt = 1'b1;
      magic_lo_nxt  = '0;
      magic_ok_nxt  = 1'b0;
      any_nz_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      magic_lo_r  <= '0;
      magic_ok_r  <= 1'b0;
      any_nz_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      magic_lo_r  <= magic_lo_nxt;
      magic_ok_r  <= magic_ok_nxt;
      any_nz_r    <= any_nz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last) verdict_r <= verdict_nxt;
  end

`ifndef NO_ASSERTIONS
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last) |=> (pos_r == '0) && out_valid_r && !magic_ok_r && !any_nz_r)
    else $error("frame end did not restart the frame");

  a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire && last))
    else $error("verdict raised without a frame end");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_byte.ready |-> (out_valid_r && !out_verdict.ready))
    else $error("input stalled without a pending verdict");
`endif

endmodule

@@ rtl/ptp_entry_check.sv @@
// Tracks table entries of the second sector and flags any malformed used entry.
module ptp_entry_check
  import ptp_pkg::*;
#(
  parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
  parameter int ENTRY_BYTES = ENTRY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ptp_step_t         step,
  input  logic              step_valid,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              failed
);

  localparam int OFF_W = $clog2(ENTRY_BYTES);
  localparam int IDX_W = $clog2(ENTRY_COUNT + 1);

  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              used_r, used_nxt;
  logic              failed_r, failed_nxt;
  logic [BYTE_W-1:0] start_sec_r, start_sec_nxt;
  logic [BYTE_W-1:0] start_hd_r, start_hd_nxt;
  logic [15:0]       start_cyl_r, start_cyl_nxt;
  logic [BYTE_W-1:0] end_sec_r, end_sec_nxt;
  logic [BYTE_W-1:0] end_hd_r, end_hd_nxt;
  logic [BYTE_W-1:0] end_cyl_lo_r, end_cyl_lo_nxt;

  logic              active;
  logic              upd;
  logic [15:0]       end_cyl;
  logic              bad_entry;

  assign active  = (idx_r < IDX_W'(ENTRY_COUNT));
  assign upd     = step_valid && step.tbl_byte && active;
  assign end_cyl = {data_byte, end_cyl_lo_r};

  always_comb begin
    bad_entry = (start_cyl_r == '0) || (end_cyl == '0) ||
                ((start_sec_r == end_sec_r) && (start_hd_r == end_hd_r) &&
                 (start_cyl_r == end_cyl));
  end

  // Includes the check of the current word so a frame end sees it
  assign failed = failed_r ||
                  (upd && (off_r == OFF_W'(OFF_END_CYH)) && used_r && bad_entry);

  always_comb begin
    off_nxt        = off_r;
    idx_nxt        = idx_r;
    used_nxt       = used_r;
    failed_nxt     = failed;
    start_sec_nxt  = start_sec_r;
    start_hd_nxt   = start_hd_r;
    start_cyl_nxt  = start_cyl_r;
    end_sec_nxt    = end_sec_r;
    end_hd_nxt     = end_hd_r;
    end_cyl_lo_nxt = end_cyl_lo_r;
    if (upd) begin
      if (off_r == OFF_W'(OFF_TYPE0)) used_nxt = (data_byte != '0);
      if (off_r == OFF_W'(OFF_TYPE1)) used_nxt = used_r && (data_byte != '0);
      if (off_r == OFF_W'(OFF_START_SEC)) start_sec_nxt = data_byte;
      if (off_r == OFF_W'(OFF_START_HD)) start_hd_nxt = data_byte;
      if (off_r == OFF_W'(OFF_START_CYL)) start_cyl_nxt = {8'd0, data_byte};
      if (off_r == OFF_W'(OFF_START_CYH)) start_cyl_nxt = {data_byte, start_cyl_r[7:0]};
      if (off_r == OFF_W'(OFF_END_SEC)) end_sec_nxt = data_byte;
      if (off_r == OFF_W'(OFF_END_HD)) end_hd_nxt = data_byte;
      if (off_r == OFF_W'(OFF_END_CYL)) end_cyl_lo_nxt = data_byte;
    end
    // advance through entries; the index stops once past the last entry
    if (step_valid && step.tbl_byte) begin
      if (off_r == OFF_W'(ENTRY_BYTES - 1)) begin
        off_nxt = '0;
        if (active) idx_nxt = idx_r + 1'b1;
      end else begin
        off_nxt = off_r + 1'b1;
      end
    end
    if (step_valid && step.frame_end) begin
      off_nxt        = '0;
      idx_nxt        = '0;
      used_nxt       = 1'b0;
      failed_nxt     = 1'b0;
      start_sec_nxt  = '0;
      start_hd_nxt   = '0;
      start_cyl_nxt  = '0;
      end_sec_nxt    = '0;
      end_hd_nxt     = '0;
      end_cyl_lo_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r        <= '0;
      idx_r        <= '0;
      used_r       <= 1'b0;
      failed_r     <= 1'b0;
      start_sec_r  <= '0;
      start_hd_r   <= '0;
      start_cyl_r  <= '0;
      end_sec_r    <= '0;
      end_hd_r     <= '0;
      end_cyl_lo_r <= '0;
    end else begin
      off_r        <= off_nxt;
      idx_r        <= idx_nxt;
      used_r       <= used_nxt;
      failed_r     <= failed_nxt;
      start_sec_r  <= start_sec_nxt;
      start_hd_r   <= start_hd_nxt;
      start_cyl_r  <= start_cyl_nxt;
      end_sec_r    <= end_sec_nxt;
      end_hd_r     <= end_hd_nxt;
      end_cyl_lo_r <= end_cyl_lo_nxt;
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench of the partition table probe: frames in, verdicts checked.
`timescale 1ns / 100ps

module testbench;
  import ptp_pkg::*;

  localparam int FRAME_BYTES  = 2 * SECTOR_BYTES_DEF;
  localparam int DRAIN_CYCLES = 8;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Kinds of table entry the frame builder can lay down
  localparam int ENT_BLANK      = 0;
  localparam int ENT_UNUSED     = 1;
  localparam int ENT_GOOD       = 2;
  localparam int ENT_NEAR_SAME  = 3;
  localparam int ENT_ZERO_START = 4;
  localparam int ENT_ZERO_END   = 5;
  localparam int ENT_SAME_CHS   = 6;

  logic clk = 1'b0;
  logic rst_n;
  logic verdict_ready = 1'b0;

  ptp_byte_if    byte_ch ();
  ptp_verdict_if verdict_ch ();
  ptp_cfg_if     cfg_ch ();

  assign verdict_ch.ready = verdict_ready;

  partition_table_probe dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_byte     (byte_ch),
    .out_verdict (verdict_ch),
    .cfg_wr      (cfg_ch)
  );

  always #5 clk = ~clk;

  // Register copies as the probe should hold them
  logic [SECT_SIZE_W-1:0]  sect_size_m  = SECTOR_SIZE_RST;
  logic [MEDIA_SIZE_W-1:0] media_size_m = MEDIA_SIZE_RST;
  logic [MAGIC_W-1:0]      magic_m      = MAGIC_VALUE_RST;

  // Frame scan state of the predictor
  logic [9:0]  frame_pos;
  logic [7:0]  sig_low;
  logic        sig_ok;
  logic        tbl_nonzero;
  logic        tbl_bad;
  logic        ent_used;
  logic [7:0]  s_sec, s_hd, e_sec, e_hd, e_cyl_lo;
  logic [15:0] s_cyl;

  verdict_t verdicts_due[$];
  verdict_t verdict_want;

  logic [7:0] frame_buf [0:FRAME_BYTES-1];

  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     mismatch_count = 0;
  longint cycle_count    = 0;

  task automatic clear_probe_state();
    frame_pos   = '0;
    sig_low     = '0;
    sig_ok      = 1'b0;
    tbl_nonzero = 1'b0;
    tbl_bad     = 1'b0;
    ent_used    = 1'b0;
    s_sec       = '0;
    s_hd        = '0;
    s_cyl       = '0;
    e_sec       = '0;
    e_hd        = '0;
    e_cyl_lo    = '0;
  endtask

  function automatic verdict_t frame_verdict();
    if (sect_size_m < SECTOR_BYTES_DEF || media_size_m < MIN_MEDIA) return VERDICT_TOO_SMALL;
    if (sect_size_m > SECTOR_BYTES_DEF) return VERDICT_BAD_SECTOR;
    if (!sig_ok) return VERDICT_NO_TABLE;
    if (!tbl_nonzero) return VERDICT_EMPTY;
    if (tbl_bad) return VERDICT_NO_TABLE;
    return VERDICT_VALID;
  endfunction

  // Advance the predictor by one accepted word
  task automatic track_byte(input logic [7:0] b);
    int rel;
    int slot;
    int off;
    logic [15:0] e_cyl;
    if (frame_pos < SECTOR_BYTES_DEF) begin
      if (frame_pos == MAGIC_OFFSET_DEF) begin
        sig_low = b;
      end else if (frame_pos == MAGIC_OFFSET_DEF + 1) begin
        sig_ok = ({b, sig_low} == magic_m);
      end
    end else begin
      rel  = int'(frame_pos) - SECTOR_BYTES_DEF;
      slot = rel / ENTRY_BYTES_DEF;
      off  = rel % ENTRY_BYTES_DEF;
      if (b != 8'h00) tbl_nonzero = 1'b1;
      if (slot < ENTRY_COUNT_DEF) begin
        case (off)
          OFF_TYPE0:     ent_used = (b != 8'h00);
          OFF_TYPE1:     ent_used = ent_used && (b != 8'h00);
          OFF_START_SEC: s_sec = b;
          OFF_START_HD:  s_hd = b;
          OFF_START_CYL: s_cyl = {8'h00, b};
          OFF_START_CYH: s_cyl = s_cyl | {b, 8'h00};
          OFF_END_SEC:   e_sec = b;
          OFF_END_HD:    e_hd = b;
          OFF_END_CYL:   e_cyl_lo = b;
          OFF_END_CYH: begin
            e_cyl = {b, e_cyl_lo};
            if (ent_used) begin
              if (s_cyl == 16'h0000 || e_cyl == 16'h0000) tbl_bad = 1'b1;
              if (s_sec == e_sec && s_hd == e_hd && s_cyl == e_cyl) tbl_bad = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
    if (frame_pos == FRAME_BYTES - 1) begin
      verdicts_due.push_back(frame_verdict());
      clear_probe_state();
    end else begin
      frame_pos = frame_pos + 10'd1;
    end
  endtask

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Check each verdict word against the oldest one due; stall at random
  always @(posedge clk) begin
    if (rst_n && verdict_ch.valid && verdict_ready) begin
      if (verdicts_due.size() == 0) begin
        flag_mismatch($sformatf("verdict %0d arrived with none due", verdict_ch.verdict));
      end else begin
        verdict_want = verdicts_due.pop_front();
        if (verdict_ch.verdict !== verdict_want) begin
          flag_mismatch($sformatf("verdict expected %0d, got %0d",
                                  verdict_want, verdict_ch.verdict));
        end
      end
    end
    verdict_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Hold valid high across back-to-back words; drop it only for an idle gap
  task automatic send_byte(input logic [7:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    track_byte(b);
  endtask

  task automatic send_frame();
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(frame_buf[i]);
  endtask

  // Stop the byte stream and wait for every verdict due
  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_SECTOR_SIZE: sect_size_m  = val[SECT_SIZE_W-1:0];
      REG_MEDIA_SIZE:  media_size_m = val[MEDIA_SIZE_W-1:0];
      REG_MAGIC_VALUE: magic_m      = val[MAGIC_W-1:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand48();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[CFG_DATA_W-1:0];
  endfunction

  function automatic int pick_entry_kind();
    int r;
    r = $urandom_range(99);
    if (r < 25) return ENT_UNUSED;
    if (r < 30) return ENT_BLANK;
    if (r < 90) return ENT_GOOD;
    if (r < 97) return ENT_NEAR_SAME;
    if (r == 97) return ENT_ZERO_START;
    if (r == 98) return ENT_ZERO_END;
    return ENT_SAME_CHS;
  endfunction

  task automatic put_entry(input int slot, input int kind);
    int base;
    base = SECTOR_BYTES_DEF + slot * ENTRY_BYTES_DEF;
    for (int k = 0; k < ENTRY_BYTES_DEF; k++) begin
      frame_buf[base+k] = (kind == ENT_BLANK) ? 8'h00 : 8'($urandom);
    end
    if (kind == ENT_UNUSED) begin
      frame_buf[base + ($urandom_range(1) ? OFF_TYPE1 : OFF_TYPE0)] = 8'h00;
    end else if (kind != ENT_BLANK) begin
      if (frame_buf[base+OFF_TYPE0] == 8'h00) frame_buf[base+OFF_TYPE0] = 8'($urandom_range(1, 255));
      if (frame_buf[base+OFF_TYPE1] == 8'h00) frame_buf[base+OFF_TYPE1] = 8'($urandom_range(1, 255));
      if (frame_buf[base+OFF_START_CYL] == 8'h00 && frame_buf[base+OFF_START_CYH] == 8'h00)
        frame_buf[base+OFF_START_CYL] = 8'($urandom_range(1, 255));
      if (frame_buf[base+OFF_END_CYL] == 8'h00 && frame_buf[base+OFF_END_CYH] == 8'h00)
        frame_buf[base+OFF_END_CYL] = 8'($urandom_range(1, 255));
      case (kind)
        ENT_GOOD: begin
          if ({frame_buf[base+OFF_START_SEC], frame_buf[base+OFF_START_HD],
               frame_buf[base+OFF_START_CYL], frame_buf[base+OFF_START_CYH]} ==
              {frame_buf[base+OFF_END_SEC], frame_buf[base+OFF_END_HD],
               frame_buf[base+OFF_END_CYL], frame_buf[base+OFF_END_CYH]})
            frame_buf[base+OFF_END_SEC] = frame_buf[base+OFF_END_SEC] ^ 8'h01;
        end
        ENT_NEAR_SAME: begin
          // keep both cylinder bytes nonzero so one flip cannot zero the end cylinder
          frame_buf[base+OFF_START_CYL] = frame_buf[base+OFF_START_CYL] | 8'h01;
          frame_buf[base+OFF_START_CYH] = frame_buf[base+OFF_START_CYH] | 8'h01;
          for (int k = 0; k < 4; k++) frame_buf[base+OFF_END_SEC+k] = frame_buf[base+OFF_START_SEC+k];
          frame_buf[base+OFF_END_SEC+$urandom_range(3)] ^= 8'($urandom_range(1, 255));
        end
        ENT_ZERO_START: begin
          frame_buf[base+OFF_START_CYL] = 8'h00;
          frame_buf[base+OFF_START_CYH] = 8'h00;
        end
        ENT_ZERO_END: begin
          frame_buf[base+OFF_END_CYL] = 8'h00;
          frame_buf[base+OFF_END_CYH] = 8'h00;
        end
        ENT_SAME_CHS: begin
          for (int k = 0; k < 4; k++) frame_buf[base+OFF_END_SEC+k] = frame_buf[base+OFF_START_SEC+k];
        end
        default: ;
      endcase
    end
  endtask

  // Random boot sector with or without a good signature; table blank or mixed
  task automatic fill_frame(input bit good_sig, input bit mixed);
    logic [MAGIC_W-1:0] sig;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      frame_buf[i] = (i < SECTOR_BYTES_DEF) ? 8'($urandom) : 8'h00;
    end
    sig = good_sig ? magic_m : magic_m ^ 16'($urandom_range(1, 16'hFFFF));
    frame_buf[MAGIC_OFFSET_DEF]   = sig[7:0];
    frame_buf[MAGIC_OFFSET_DEF+1] = sig[15:8];
    if (mixed) begin
      for (int e = 0; e < ENTRY_COUNT_DEF; e++) put_entry(e, pick_entry_kind());
    end
  endtask

  task automatic test_default_config();
    fill_frame(1'b1, 1'b0);
    put_entry(0, ENT_GOOD);
    send_frame();
    fill_frame(1'b1, 1'b0);
    send_frame();
    fill_frame(1'b1, 1'b1);
    send_frame();
  endtask

  task automatic test_signature();
    logic [CFG_DATA_W-1:0] val;
    fill_frame(1'b0, 1'b0);
    put_entry(1, ENT_GOOD);
    send_frame();
    // byte order swapped
    fill_frame(1'b1, 1'b0);
    put_entry(1, ENT_GOOD);
    {frame_buf[MAGIC_OFFSET_DEF], frame_buf[MAGIC_OFFSET_DEF+1]} =
      {frame_buf[MAGIC_OFFSET_DEF+1], frame_buf[MAGIC_OFFSET_DEF]};
    send_frame();
    val = rand48();
    val[MAGIC_W-1:0] = '0;
    write_reg(REG_MAGIC_VALUE, val);
    fill_frame(1'b1, 1'b0);
    send_frame();
    val[MAGIC_W-1:0] = '1;
    write_reg(REG_MAGIC_VALUE, val);
    fill_frame(1'b1, 1'b0);
    put_entry(9, ENT_GOOD);
    send_frame();
    val = rand48();
    val[MAGIC_W-1:0] = MAGIC_VALUE_RST;
    write_reg(REG_MAGIC_VALUE, val);
  endtask

  task automatic test_entry_rules();
    int base;
    fill_frame(1'b1, 1'b0);
    put_entry(0, ENT_ZERO_START);
    send_frame();
    fill_frame(1'b1, 1'b0);
    put_entry(3, ENT_ZERO_END);
    send_frame();
    fill_frame(1'b1, 1'b0);
    put_entry(ENTRY_COUNT_DEF - 1, ENT_SAME_CHS);
    send_frame();
    // unused entries with zero cylinders must not fail the table
    fill_frame(1'b1, 1'b0);
    put_entry(0, ENT_GOOD);
    put_entry(2, ENT_UNUSED);
    put_entry(5, ENT_UNUSED);
    base = SECTOR_BYTES_DEF + 2 * ENTRY_BYTES_DEF;
    frame_buf[base+OFF_START_CYL] = 8'h00;
    frame_buf[base+OFF_START_CYH] = 8'h00;
    frame_buf[base+OFF_END_CYL]   = 8'h00;
    frame_buf[base+OFF_END_CYH]   = 8'h00;
    send_frame();
    // lone nonzero filler byte: not empty, nothing used
    fill_frame(1'b1, 1'b0);
    frame_buf[SECTOR_BYTES_DEF + 7 * ENTRY_BYTES_DEF + 5] = 8'h80;
    send_frame();
    fill_frame(1'b1, 1'b0);
    for (int e = 0; e < ENTRY_COUNT_DEF; e++) put_entry(e, ENT_NEAR_SAME);
    send_frame();
    fill_frame(1'b1, 1'b0);
    for (int e = 0; e < ENTRY_COUNT_DEF; e++) put_entry(e, ENT_GOOD);
    send_frame();
    // every byte all ones: entries used with equal start and end
    for (int i = 0; i < FRAME_BYTES; i++) frame_buf[i] = 8'hFF;
    frame_buf[MAGIC_OFFSET_DEF]   = magic_m[7:0];
    frame_buf[MAGIC_OFFSET_DEF+1] = magic_m[15:8];
    send_frame();
  endtask

  task automatic test_medium_checks();
    logic [CFG_DATA_W-1:0] val;
    val = rand48();
    val[15:0] = SECTOR_SIZE_RST - 16'd1;
    write_reg(REG_SECTOR_SIZE, val);
    fill_frame(1'b1, 1'b1);
    send_frame();
    val[15:0] = '0;
    write_reg(REG_SECTOR_SIZE, val);
    fill_frame(1'b1, 1'b1);
    send_frame();
    val[15:0] = SECTOR_SIZE_RST + 16'd1;
    write_reg(REG_SECTOR_SIZE, val);
    fill_frame(1'b1, 1'b1);
    send_frame();
    val[15:0] = '1;
    write_reg(REG_SECTOR_SIZE, val);
    fill_frame(1'b1, 1'b1);
    send_frame();
    // too small wins over an unsupported sector size
    write_reg(REG_MEDIA_SIZE, MIN_MEDIA - 1);
    fill_frame(1'b1, 1'b1);
    send_frame();
    val[15:0] = SECTOR_SIZE_RST;
    write_reg(REG_SECTOR_SIZE, val);
    fill_frame(1'b1, 1'b1);
    send_frame();
    write_reg(REG_MEDIA_SIZE, '0);
    fill_frame(1'b1, 1'b1);
    send_frame();
    write_reg(REG_MEDIA_SIZE, '1);
    fill_frame(1'b1, 1'b1);
    send_frame();
    val[15:0] = '0;
    write_reg(REG_SECTOR_SIZE, val);
    fill_frame(1'b1, 1'b1);
    send_frame();
    val[15:0] = SECTOR_SIZE_RST;
    write_reg(REG_SECTOR_SIZE, val);
    write_reg(REG_MEDIA_SIZE, MIN_MEDIA);
    // write to an index past the register list must change nothing
    write_reg(REG_UNUSED, '0);
    fill_frame(1'b1, 1'b1);
    send_frame();
    write_reg(REG_UNUSED, '1);
    fill_frame(1'b1, 1'b0);
    send_frame();
  endtask

  task automatic shuffle_config();
    logic [CFG_DATA_W-1:0] val;
    int pick;
    val  = rand48();
    pick = $urandom_range(99);
    case ($urandom_range(3))
      0: begin
        if (pick < 70) val[15:0] = SECTOR_SIZE_RST;
        else if (pick < 80) val[15:0] = SECTOR_SIZE_RST - 16'd1;
        else if (pick < 90) val[15:0] = SECTOR_SIZE_RST + 16'd1;
        write_reg(REG_SECTOR_SIZE, val);
      end
      1: begin
        if (pick < 10) val = MIN_MEDIA - 1;
        else if (pick < 20) val = MIN_MEDIA;
        else if (pick < 30) val = {35'd0, 13'($urandom)};
        write_reg(REG_MEDIA_SIZE, val);
      end
      2: begin
        if (pick < 50) val[15:0] = MAGIC_VALUE_RST;
        write_reg(REG_MAGIC_VALUE, val);
      end
      default: write_reg(REG_UNUSED, val);
    endcase
  endtask

  // Mostly well-formed frames with random content; some blank, broken or noise
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int frames);
    int pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (frames) begin
      if ($urandom_range(3) == 0) shuffle_config();
      pick = $urandom_range(99);
      if (pick < 78) begin
        fill_frame(1'b1, 1'b1);
      end else if (pick < 88) begin
        fill_frame(1'b1, 1'b0);
      end else if (pick < 94) begin
        fill_frame(1'b0, 1'b1);
      end else begin
        for (int i = 0; i < FRAME_BYTES; i++) frame_buf[i] = 8'($urandom);
      end
      send_frame();
    end
    settle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_SECTOR_SIZE;
    cfg_ch.data       <= '0;
    rst_n             <= 1'b0;
    clear_probe_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_default_config();
    test_signature();
    test_entry_rules();
    test_medium_checks();
    test_random_traffic(0, 0, 15);
    test_random_traffic(84, 0, 15);
    test_random_traffic(0, 84, 15);
    test_random_traffic(30, 30, 15);

    settle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
